// ----- design/spvg_pkg.sv -----
// Shared types, constants and the sine table function of the star vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package spvg_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int TRIG_FRAC_BITS_DEF = 15;

   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint ONE_Q30 = 64'sd1073741824;

   // Taylor term denominators (2n)(2n+1) for n = 1..9
   localparam longint TAYLOR_DIV [9] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
                                         64'sd156, 64'sd210, 64'sd272, 64'sd342};

   localparam logic [19:0] RADIUS_MAX = 20'hFFFFF;
   localparam logic [19:0] RADIUS_RESET = 20'd12800;

   localparam int FULL_DEG = 360;
   localparam int RIGHT_DEG = 90;
   localparam int HALF_DEG = 180;
   localparam int THREE_Q_DEG = 270;
   localparam int STEP_DEG = 72;

   typedef enum logic [2:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_SPEED_X = 3'd2,
      CSR_SPEED_Y = 3'd3,
      CSR_DIR_X = 3'd4,
      CSR_DIR_Y = 3'd5,
      CSR_INIT_RADIUS = 3'd6
   } csr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   // sine of k whole degrees, k in 0..90, Taylor series in Q2.30, rounded to frac bits
   function automatic longint sin_quarter(input int k, input int frac);
      longint x;
      longint x2;
      longint term;
      longint sum;
      int sh;
      x = longint'(k) * PI_Q30 / HALF_DEG;
      x2 = (x * x) / ONE_Q30;
      term = x;
      sum = x;
      sh = 30 - frac;
      for (int n = 1; n <= 9; n++) begin
         term = -((term * x2) / ONE_Q30);
         term = term / TAYLOR_DIV[n - 1];
         sum = sum + term;
      end
      if (sum < 0) begin
         sum = 0;
      end
      return (sum + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

endpackage
`default_nettype wire

// ----- design/spvg_mul.sv -----
// Shared modular multiplier built from three half-width partial products.
`timescale 1ns / 1ps
`default_nettype none
module spvg_mul #(
   parameter int W = 54
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [W-1:0]         a,
   input  wire logic [W-1:0]         b,
   output logic [W-1:0]              product,
   output spvg_pkg::unit_sts_type    sts
);

   localparam int H = (W + 1) / 2;

   logic [W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [H-1:0] op_a, op_b;
   logic [2*H-1:0] part;

   always_comb begin
      op_a = a_ff[H-1:0];
      op_b = b_ff[H-1:0];
      case (step_ff)
         2'd1: op_a = H'(a_ff[W-1:H]);
         2'd2: op_b = H'(b_ff[W-1:H]);
         default: ;
      endcase
   end

   assign part = op_a * op_b;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = W'(part);
         end else begin
            acc_in = acc_ff + (W'(part) << H);
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ----- design/spvg_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module spvg_div #(
   parameter int W = 54
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [W-1:0]         num,
   input  wire logic [W-1:0]         den,
   output logic [W-1:0]              quot,
   output spvg_pkg::unit_sts_type    sts
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0] q_ff, q_in, d_ff, d_in;
   logic [W:0] rem_ff, rem_in, rem_sh, trial;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;

   assign rem_sh = {rem_ff[W-1:0], q_ff[W-1]};
   assign trial = rem_sh - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = num[W-1] ? (~num + 1'b1) : num;
         d_in = den[W-1] ? (~den + 1'b1) : den;
         rem_in = '0;
         cnt_in = CW'(W);
         neg_in = num[W-1] ^ den[W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[W-2:0], ~trial[W]};
         rem_in = trial[W] ? rem_sh : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign quot = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ----- design/star_polygon_vertex_generator_unit.sv -----
// Top level of the star vertex generator: sequencer, trig table, vertex ring and output register.
//
//  channel  | direction | ports                                 | transfer
//  csr      | in        | csr_we, csr_index, csr_wdata          | csr_we high
//  req      | in        | req_tvalid/tready/tdata               | one frame tick
//  rsp      | out       | rsp_tvalid/tready/tdata/tuser/tlast   | one vertex, ten per tick
//
//  NW = min(64, 3 * COORD_BITS + 6). The inner points are set by two NW-step divisions
//  (none when the determinant is zero) and ten three-step products of the shared multiplier
//  each. req_tready is high only while the sequencer is idle. Reset is synchronous and
//  clears the control state at once. A stalled rsp holds its register and the sequencer
//  waits before the next vertex.
`timescale 1ns / 1ps
`default_nettype none
module star_polygon_vertex_generator_unit #(
   parameter int COORD_BITS = spvg_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = spvg_pkg::TRIG_FRAC_BITS_DEF,
   localparam int RspDataBits = ((2 * COORD_BITS + 4 + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [19:0]             csr_wdata,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [31:0]             req_tdata,   // frame_number, scale
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataBits-1:0]       rsp_tdata,   // vertex_x, vertex_y, vertex_index
   output logic                         rsp_tuser,   // degenerate
   output logic                         rsp_tlast
);

   localparam int C = COORD_BITS;
   localparam int NW = (3 * COORD_BITS + 6 > 64) ? 64 : 3 * COORD_BITS + 6;
   localparam int LutBits = TRIG_FRAC_BITS + 1;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = 21 + TW;
   localparam int SH = 8 + TRIG_FRAC_BITS;
   localparam int QW = PW - SH;
   localparam logic signed [63:0] CoordMax = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] CoordMin = -CoordMax - 64'sd1;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_SCALE   = 15'b000000000000010,
      ST_MOD     = 15'b000000000000100,
      ST_ANG     = 15'b000000000001000,
      ST_OMULX   = 15'b000000000010000,
      ST_OADDX   = 15'b000000000100000,
      ST_OMULY   = 15'b000000001000000,
      ST_OADDY   = 15'b000000010000000,
      ST_DIFF    = 15'b000000100000000,
      ST_MULGO   = 15'b000001000000000,
      ST_MULWAIT = 15'b000010000000000,
      ST_DIVGO   = 15'b000100000000000,
      ST_DIVWAIT = 15'b001000000000000,
      ST_EMITO   = 15'b010000000000000,
      ST_EMITI   = 15'b100000000000000
   } state_type;

   function automatic logic signed [C-1:0] sat_c(input logic signed [63:0] v);
      logic signed [C-1:0] r;
      r = C'(v);
      if (v > CoordMax) begin
         r = C'(CoordMax);
      end else if (v < CoordMin) begin
         r = C'(CoordMin);
      end
      return r;
   endfunction

   // quarter-wave fold: returns {negate, table index}
   function automatic logic [7:0] fold(input logic [8:0] a);
      logic [7:0] r;
      if (a <= 9'(spvg_pkg::RIGHT_DEG)) begin
         r = {1'b0, a[6:0]};
      end else if (a <= 9'(spvg_pkg::HALF_DEG)) begin
         r = {1'b0, 7'(9'(spvg_pkg::HALF_DEG) - a)};
      end else if (a <= 9'(spvg_pkg::THREE_Q_DEG)) begin
         r = {1'b1, 7'(a - 9'(spvg_pkg::HALF_DEG))};
      end else begin
         r = {1'b1, 7'(9'(spvg_pkg::FULL_DEG) - a)};
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic signed [C-1:0] center_x_ff, center_x_in, center_y_ff, center_y_in;
   logic [19:0] radius_ff, radius_in;
   logic [7:0] speed_x_ff, speed_x_in, speed_y_ff, speed_y_in;
   logic [1:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [15:0] frame_ff, frame_in, scale_ff, scale_in;
   logic [23:0] rem_ff, rem_in;
   logic [3:0] bit_ff, bit_in;
   logic [8:0] ang_ff, ang_in;
   logic [2:0] cnt_ff, cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [C-1:0] px_ff, px_in;
   logic signed [C-1:0] ring_x_ff [5];
   logic signed [C-1:0] ring_x_in [5];
   logic signed [C-1:0] ring_y_ff [5];
   logic signed [C-1:0] ring_y_in [5];
   logic [NW-1:0] ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in, cd_ff, cd_in;
   logic [NW-1:0] ce_ff, ce_in, cf_ff, cf_in, det_ff, det_in;
   logic [NW-1:0] nx_ff, nx_in, ny_ff, ny_in, tmp_ff, tmp_in;
   logic [3:0] mstep_ff, mstep_in;
   logic div_y_ff, div_y_in;
   logic signed [C-1:0] ix_ff, ix_in, iy_ff, iy_in;
   logic deg_ff, deg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [C-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [3:0] rsp_idx_ff, rsp_idx_in;
   logic rsp_deg_ff, rsp_deg_in, rsp_last_ff, rsp_last_in;

   logic [LutBits-1:0] sin_lut [91];
   logic [8:0] cos_ang;
   logic [7:0] sin_f, cos_f;
   logic signed [TW-1:0] sin_val, cos_val;
   logic signed [PW-1:0] trunc_bias, trunc_full;
   logic signed [QW-1:0] trunc_q;
   logic [35:0] rad_prod;
   logic [24:0] mod_sub, mod_trial;
   logic signed [9:0] step_x, step_y;
   logic signed [C:0] diff_a, diff_b, diff_c, diff_d;
   logic out_free;

   logic mul_start, div_start;
   logic [NW-1:0] mul_a, mul_b, mul_p, div_num, div_quot;
   spvg_pkg::unit_sts_type mul_sts, div_sts;

   for (genvar g = 0; g <= 90; g++) begin : g_lut
      assign sin_lut[g] = LutBits'(spvg_pkg::sin_quarter(g, TRIG_FRAC_BITS));
   end

   assign cos_ang = (ang_ff >= 9'(spvg_pkg::THREE_Q_DEG)) ?
                    ang_ff - 9'(spvg_pkg::THREE_Q_DEG) : ang_ff + 9'(spvg_pkg::RIGHT_DEG);
   assign sin_f = fold(ang_ff);
   assign cos_f = fold(cos_ang);
   assign sin_val = sin_f[7] ? -signed'(TW'(sin_lut[sin_f[6:0]])) :
                    signed'(TW'(sin_lut[sin_f[6:0]]));
   assign cos_val = cos_f[7] ? -signed'(TW'(sin_lut[cos_f[6:0]])) :
                    signed'(TW'(sin_lut[cos_f[6:0]]));

   assign trunc_bias = prod_ff[PW-1] ? PW'((64'd1 << SH) - 64'd1) : '0;
   assign trunc_full = (prod_ff + trunc_bias) >>> SH;
   assign trunc_q = trunc_full[QW-1:0];

   assign rad_prod = radius_ff * scale_ff;
   assign mod_sub = 25'(spvg_pkg::FULL_DEG) << bit_ff;
   assign mod_trial = {1'b0, rem_ff} - mod_sub;

   always_comb begin
      step_x = '0;
      step_y = '0;
      if (dir_x_ff == 2'b01) step_x = signed'({2'b00, speed_x_ff});
      if (dir_x_ff == 2'b11) step_x = -signed'({2'b00, speed_x_ff});
      if (dir_y_ff == 2'b01) step_y = signed'({2'b00, speed_y_ff});
      if (dir_y_ff == 2'b11) step_y = -signed'({2'b00, speed_y_ff});
   end

   assign diff_a = (C+1)'(ring_y_ff[0]) - (C+1)'(ring_y_ff[2]);
   assign diff_b = (C+1)'(ring_x_ff[2]) - (C+1)'(ring_x_ff[0]);
   assign diff_c = (C+1)'(ring_y_ff[1]) - (C+1)'(ring_y_ff[4]);
   assign diff_d = (C+1)'(ring_x_ff[4]) - (C+1)'(ring_x_ff[1]);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (mstep_ff)
         4'd0: begin mul_a = ca_ff; mul_b = NW'(ring_x_ff[0]); end
         4'd1: begin mul_a = cb_ff; mul_b = NW'(ring_y_ff[0]); end
         4'd2: begin mul_a = cc_ff; mul_b = NW'(ring_x_ff[1]); end
         4'd3: begin mul_a = cd_ff; mul_b = NW'(ring_y_ff[1]); end
         4'd4: begin mul_a = ca_ff; mul_b = cd_ff; end
         4'd5: begin mul_a = cb_ff; mul_b = cc_ff; end
         4'd6: begin mul_a = ce_ff; mul_b = cd_ff; end
         4'd7: begin mul_a = cb_ff; mul_b = cf_ff; end
         4'd8: begin mul_a = ca_ff; mul_b = cf_ff; end
         4'd9: begin mul_a = ce_ff; mul_b = cc_ff; end
         default: ;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign div_num = div_y_ff ? ny_ff : nx_ff;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      logic [NW-1:0] pair;
      state_in = state_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      radius_in = radius_ff;
      speed_x_in = speed_x_ff;
      speed_y_in = speed_y_ff;
      dir_x_in = dir_x_ff;
      dir_y_in = dir_y_ff;
      frame_in = frame_ff;
      scale_in = scale_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      ang_in = ang_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      px_in = px_ff;
      ring_x_in = ring_x_ff;
      ring_y_in = ring_y_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      cc_in = cc_ff;
      cd_in = cd_ff;
      ce_in = ce_ff;
      cf_in = cf_ff;
      det_in = det_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      tmp_in = tmp_ff;
      mstep_in = mstep_ff;
      div_y_in = div_y_ff;
      ix_in = ix_ff;
      iy_in = iy_ff;
      deg_in = deg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_deg_in = rsp_deg_ff;
      rsp_last_in = rsp_last_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      pair = (mstep_ff < 4'd4) ? tmp_ff + mul_p : tmp_ff - mul_p;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               frame_in = req_tdata[15:0];
               scale_in = req_tdata[31:16];
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            center_x_in = sat_c(64'(center_x_ff) + 64'(step_x));
            center_y_in = sat_c(64'(center_y_ff) + 64'(step_y));
            radius_in = (|rad_prod[35:28]) ? spvg_pkg::RADIUS_MAX : rad_prod[27:8];
            rem_in = frame_ff * speed_x_ff;
            bit_in = 4'd15;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (!mod_trial[24]) rem_in = mod_trial[23:0];
            bit_in = bit_ff - 4'd1;
            if (bit_ff == 4'd0) state_in = ST_ANG;
         end
         ST_ANG: begin
            ang_in = (rem_ff[8:0] <= 9'(spvg_pkg::RIGHT_DEG)) ?
                     9'(spvg_pkg::RIGHT_DEG) - rem_ff[8:0] :
                     9'(spvg_pkg::FULL_DEG + spvg_pkg::RIGHT_DEG) - rem_ff[8:0];
            cnt_in = 3'd0;
            state_in = ST_OMULX;
         end
         ST_OMULX: begin
            prod_in = signed'({1'b0, radius_ff}) * cos_val;
            state_in = ST_OADDX;
         end
         ST_OADDX: begin
            px_in = sat_c(64'(center_x_ff) + 64'(trunc_q));
            state_in = ST_OMULY;
         end
         ST_OMULY: begin
            prod_in = signed'({1'b0, radius_ff}) * sin_val;
            state_in = ST_OADDY;
         end
         ST_OADDY: begin
            for (int k = 0; k < 4; k++) begin
               ring_x_in[k] = ring_x_ff[k+1];
               ring_y_in[k] = ring_y_ff[k+1];
            end
            ring_x_in[4] = px_ff;
            ring_y_in[4] = sat_c(64'(center_y_ff) - 64'(trunc_q));
            ang_in = (ang_ff >= 9'(spvg_pkg::STEP_DEG)) ? ang_ff - 9'(spvg_pkg::STEP_DEG) :
                     ang_ff + 9'(spvg_pkg::FULL_DEG - spvg_pkg::STEP_DEG);
            if (cnt_ff == 3'd4) begin
               cnt_in = 3'd0;
               state_in = ST_DIFF;
            end else begin
               cnt_in = cnt_ff + 3'd1;
               state_in = ST_OMULX;
            end
         end
         ST_DIFF: begin
            ca_in = NW'(diff_a);
            cb_in = NW'(diff_b);
            cc_in = NW'(diff_c);
            cd_in = NW'(diff_d);
            mstep_in = 4'd0;
            state_in = ST_MULGO;
         end
         ST_MULGO: begin
            mul_start = 1'b1;
            state_in = ST_MULWAIT;
         end
         ST_MULWAIT: begin
            if (mul_sts.done) begin
               if (!mstep_ff[0]) begin
                  tmp_in = mul_p;
               end else begin
                  case (mstep_ff[3:1])
                     3'd0: ce_in = pair;
                     3'd1: cf_in = pair;
                     3'd2: det_in = pair;
                     3'd3: nx_in = pair;
                     default: ny_in = pair;
                  endcase
               end
               if (mstep_ff == 4'd9) begin
                  div_y_in = 1'b0;
                  state_in = ST_DIVGO;
               end else begin
                  mstep_in = mstep_ff + 4'd1;
                  state_in = ST_MULGO;
               end
            end
         end
         ST_DIVGO: begin
            if (det_ff == '0) begin
               ix_in = center_x_ff;
               iy_in = center_y_ff;
               deg_in = 1'b1;
               state_in = ST_EMITO;
            end else begin
               deg_in = 1'b0;
               div_start = 1'b1;
               state_in = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            if (div_sts.done) begin
               if (!div_y_ff) begin
                  ix_in = sat_c(64'(signed'(div_quot)));
                  div_y_in = 1'b1;
                  state_in = ST_DIVGO;
               end else begin
                  iy_in = sat_c(64'(signed'(div_quot)));
                  state_in = ST_EMITO;
               end
            end
         end
         ST_EMITO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = ring_x_ff[0];
               rsp_y_in = ring_y_ff[0];
               rsp_idx_in = {cnt_ff, 1'b0};
               rsp_deg_in = 1'b0;
               rsp_last_in = 1'b0;
               state_in = ST_EMITI;
            end
         end
         ST_EMITI: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = ix_ff;
               rsp_y_in = iy_ff;
               rsp_idx_in = {cnt_ff, 1'b1};
               rsp_deg_in = deg_ff;
               rsp_last_in = (cnt_ff == 3'd4);
               for (int k = 0; k < 4; k++) begin
                  ring_x_in[k] = ring_x_ff[k+1];
                  ring_y_in[k] = ring_y_ff[k+1];
               end
               ring_x_in[4] = ring_x_ff[0];
               ring_y_in[4] = ring_y_ff[0];
               if (cnt_ff == 3'd4) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
                  state_in = ST_DIFF;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         unique case (spvg_pkg::csr_type'(csr_index))
            spvg_pkg::CSR_START_X: center_x_in = sat_c(64'(signed'(csr_wdata[15:0])));
            spvg_pkg::CSR_START_Y: center_y_in = sat_c(64'(signed'(csr_wdata[15:0])));
            spvg_pkg::CSR_SPEED_X: speed_x_in = csr_wdata[7:0];
            spvg_pkg::CSR_SPEED_Y: speed_y_in = csr_wdata[7:0];
            spvg_pkg::CSR_DIR_X: dir_x_in = (csr_wdata[1:0] == 2'b10) ? 2'b11 : csr_wdata[1:0];
            spvg_pkg::CSR_DIR_Y: dir_y_in = (csr_wdata[1:0] == 2'b10) ? 2'b11 : csr_wdata[1:0];
            spvg_pkg::CSR_INIT_RADIUS: radius_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff <= spvg_pkg::RADIUS_RESET;
         speed_x_ff <= 8'd1;
         speed_y_ff <= 8'd1;
         dir_x_ff <= 2'b01;
         dir_y_ff <= 2'b01;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         radius_ff <= radius_in;
         speed_x_ff <= speed_x_in;
         speed_y_ff <= speed_y_in;
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      scale_ff <= scale_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      ang_ff <= ang_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      px_ff <= px_in;
      ring_x_ff <= ring_x_in;
      ring_y_ff <= ring_y_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
      cc_ff <= cc_in;
      cd_ff <= cd_in;
      ce_ff <= ce_in;
      cf_ff <= cf_in;
      det_ff <= det_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      tmp_ff <= tmp_in;
      mstep_ff <= mstep_in;
      div_y_ff <= div_y_in;
      ix_ff <= ix_in;
      iy_ff <= iy_in;
      deg_ff <= deg_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_deg_ff <= rsp_deg_in;
      rsp_last_ff <= rsp_last_in;
   end

   spvg_mul #(.W(NW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p),
      .sts     (mul_sts)
   );

   spvg_div #(.W(NW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (det_ff),
      .quot  (div_quot),
      .sts   (div_sts)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RspDataBits'({rsp_idx_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tuser = rsp_deg_ff;
   assign rsp_tlast = rsp_last_ff;

   a_last_on_nine: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_idx_ff == 4'd9)
      else $error("last flag on a vertex other than the tenth");

   a_deg_inner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_deg_ff |-> rsp_idx_ff[0])
      else $error("degenerate flag on an outer vertex");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again right after a transfer");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("multiplier started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the star vertex generator: directed table, then random frames.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int CLK_HALF = 5;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int ITEMS_PER_PHASE = 64;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0] index;
      logic [19:0] wdata;
      logic [15:0] frame;
      logic [15:0] scale;
      bit fixed_v0;
      logic signed [15:0] v0_x;
      logic signed [15:0] v0_y;
   } stim_row_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [3:0] index;
      logic degenerate;
      logic last;
   } vertex_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [19:0] csr_wdata;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [39:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   star_polygon_vertex_generator_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   vertex_type pending_vertices[$];
   stim_row_type stim_rows[$];
   int error_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   longint star_cx, star_cy, star_rad;
   longint speed_x_q, speed_y_q, dir_x_q, dir_y_q;
   longint outer_x[5], outer_y[5];

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            report_mismatch("unexpected vertex index", rsp_tdata[35:32], -1);
         end else begin
            want = pending_vertices.pop_front();
            if ($signed(rsp_tdata[15:0]) !== want.x)
               report_mismatch("vertex_x", $signed(rsp_tdata[15:0]), want.x);
            if ($signed(rsp_tdata[31:16]) !== want.y)
               report_mismatch("vertex_y", $signed(rsp_tdata[31:16]), want.y);
            if (rsp_tdata[35:32] !== want.index)
               report_mismatch("vertex_index", rsp_tdata[35:32], want.index);
            if (rsp_tuser !== want.degenerate)
               report_mismatch("degenerate", rsp_tuser, want.degenerate);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
   end

   function automatic longint sat_coord(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint quarter_sine(input longint k);
      longint x, x2, term, sum;
      x = k * 64'sd3373259426 / 180;
      x2 = (x * x) / (64'sd1 <<< 30);
      term = x;
      sum = x;
      for (int n = 1; n <= 9; n++) begin
         term = -((term * x2) / (64'sd1 <<< 30));
         term = term / longint'((2 * n) * (2 * n + 1));
         sum = sum + term;
      end
      if (sum < 0) sum = 0;
      return (sum + (64'sd1 <<< 14)) >>> 15;
   endfunction

   function automatic longint sine_deg(input longint a);
      if (a <= 90) return quarter_sine(a);
      if (a <= 180) return quarter_sine(180 - a);
      if (a <= 270) return -quarter_sine(a - 180);
      return -quarter_sine(360 - a);
   endfunction

   function automatic longint sext_bits(input logic [19:0] v, input int bits);
      longint r;
      r = v & ((64'sd1 <<< bits) - 1);
      if (r >= (64'sd1 <<< (bits - 1))) r = r - (64'sd1 <<< bits);
      return r;
   endfunction

   task automatic apply_csr_model(input logic [2:0] index, input logic [19:0] wdata);
      case (index)
         spvg_pkg::CSR_START_X: star_cx = sext_bits(wdata, 16);
         spvg_pkg::CSR_START_Y: star_cy = sext_bits(wdata, 16);
         spvg_pkg::CSR_SPEED_X: speed_x_q = wdata[7:0];
         spvg_pkg::CSR_SPEED_Y: speed_y_q = wdata[7:0];
         spvg_pkg::CSR_DIR_X: dir_x_q = (sext_bits(wdata, 2) < -1) ? -1 : sext_bits(wdata, 2);
         spvg_pkg::CSR_DIR_Y: dir_y_q = (sext_bits(wdata, 2) < -1) ? -1 : sext_bits(wdata, 2);
         spvg_pkg::CSR_INIT_RADIUS: star_rad = wdata;
         default: ;
      endcase
   endtask

   task automatic push_star_vertices(input logic [15:0] frame, input logic [15:0] scale,
                                     input stim_row_type row);
      longint ang, s, c, a, b, cc, d, e, f, det, nx, ny, ix, iy;
      int j2, j3, j4;
      vertex_type v;
      star_cx = sat_coord(star_cx + speed_x_q * dir_x_q);
      star_cy = sat_coord(star_cy + speed_y_q * dir_y_q);
      star_rad = (star_rad * longint'(scale)) >>> 8;
      if (star_rad > 1048575) star_rad = 1048575;
      for (int i = 0; i < 5; i++) begin
         ang = (90 - 72 * longint'(i) - longint'(frame) * speed_x_q) % 360;
         if (ang < 0) ang += 360;
         s = sine_deg(ang);
         c = sine_deg((ang + 90) % 360);
         outer_x[i] = sat_coord(star_cx + (star_rad * c) / (64'sd1 <<< 23));
         outer_y[i] = sat_coord(star_cy - (star_rad * s) / (64'sd1 <<< 23));
      end
      for (int i = 0; i < 5; i++) begin
         j2 = (i + 2) % 5;
         j3 = (i + 1) % 5;
         j4 = (i + 4) % 5;
         v.x = 16'(outer_x[i]);
         v.y = 16'(outer_y[i]);
         if (i == 0 && row.fixed_v0) begin
            v.x = row.v0_x;
            v.y = row.v0_y;
         end
         v.index = 4'(2 * i);
         v.degenerate = 1'b0;
         v.last = 1'b0;
         pending_vertices.push_back(v);
         a = outer_y[i] - outer_y[j2];
         b = outer_x[j2] - outer_x[i];
         cc = outer_y[j3] - outer_y[j4];
         d = outer_x[j4] - outer_x[j3];
         e = a * outer_x[i] + b * outer_y[i];
         f = cc * outer_x[j3] + d * outer_y[j3];
         det = a * d - b * cc;
         nx = e * d - b * f;
         ny = a * f - e * cc;
         if (det == 0) begin
            ix = star_cx;
            iy = star_cy;
         end else if (det == -1) begin
            ix = sat_coord(-nx);
            iy = sat_coord(-ny);
         end else begin
            ix = sat_coord(nx / det);
            iy = sat_coord(ny / det);
         end
         v.x = 16'(ix);
         v.y = 16'(iy);
         v.index = 4'(2 * i + 1);
         v.degenerate = (det == 0);
         v.last = (i == 4);
         pending_vertices.push_back(v);
      end
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [19:0] wdata);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = wdata;
      apply_csr_model(index, wdata);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_frame(input logic [15:0] frame, input logic [15:0] scale,
                             input stim_row_type row);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {scale, frame};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      push_star_vertices(frame, scale, row);
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata = $urandom;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [2:0] index,
                          input logic [19:0] wdata, input logic [15:0] frame,
                          input logic [15:0] scale, input bit fixed_v0,
                          input int v0_x, input int v0_y);
      stim_row_type r;
      r.kind = kind;
      r.index = index;
      r.wdata = wdata;
      r.frame = frame;
      r.scale = scale;
      r.fixed_v0 = fixed_v0;
      r.v0_x = 16'(v0_x);
      r.v0_y = 16'(v0_y);
      stim_rows.push_back(r);
   endtask

   task automatic random_config(input bit extreme);
      if (extreme) begin
         write_csr(spvg_pkg::CSR_START_X, $urandom_range(1) ? 20'h07FFF : 20'h08000);
         write_csr(spvg_pkg::CSR_START_Y, $urandom_range(1) ? 20'h07FFF : 20'h08000);
         write_csr(spvg_pkg::CSR_SPEED_X, $urandom_range(1) ? 20'd255 : 20'd0);
         write_csr(spvg_pkg::CSR_SPEED_Y, $urandom_range(1) ? 20'd255 : 20'd0);
         write_csr(spvg_pkg::CSR_INIT_RADIUS, $urandom_range(1) ? 20'hFFFFF : 20'h00000);
      end else begin
         write_csr(spvg_pkg::CSR_START_X, 20'($urandom_range(20'hFFFFF)));
         write_csr(spvg_pkg::CSR_START_Y, 20'($urandom_range(20'hFFFFF)));
         write_csr(spvg_pkg::CSR_SPEED_X, 20'($urandom_range(20'hFFFFF)));
         write_csr(spvg_pkg::CSR_SPEED_Y, 20'($urandom_range(20'hFFFFF)));
         write_csr(spvg_pkg::CSR_INIT_RADIUS,
                   ($urandom_range(3) == 0) ? 20'($urandom_range(20'hFFFFF)) :
                                              20'($urandom_range(60000)));
      end
      write_csr(spvg_pkg::CSR_DIR_X, 20'($urandom_range(20'hFFFFF)));
      write_csr(spvg_pkg::CSR_DIR_Y, 20'($urandom_range(20'hFFFFF)));
   endtask

   initial begin
      stim_row_type row;
      stim_row_type plain;
      logic [15:0] scale;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = spvg_pkg::CSR_START_X;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      star_cx = 0;
      star_cy = 0;
      star_rad = 12800;
      speed_x_q = 1;
      speed_y_q = 1;
      dir_x_q = 1;
      dir_y_q = 1;
      plain = '{kind: ROW_FRAME, index: spvg_pkg::CSR_START_X, wdata: '0, frame: '0,
                scale: '0, fixed_v0: 1'b0, v0_x: '0, v0_y: '0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd0, 16'd256, 1, 1, -49);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd1234, 16'd0, 1, 3, 3);
      add_row(ROW_CSR, spvg_pkg::CSR_INIT_RADIUS, 20'hFFFFF, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_START_X, 20'h07FFF, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_START_Y, 20'h08000, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_SPEED_X, 20'd255, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_SPEED_Y, 20'd255, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_DIR_X, 20'd1, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_DIR_Y, 20'd2, 0, 0, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd7, 16'd256, 0, 0, 0);
      add_row(ROW_CSR, CSR_UNUSED, 20'hABCDE, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_DIR_X, 20'd0, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_DIR_Y, 20'd3, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_SPEED_X, 20'd0, 0, 0, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd100, 16'd128, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd0, 16'd300, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_START_X, 20'd0, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_START_Y, 20'd0, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_INIT_RADIUS, 20'd0, 0, 0, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd45, 16'hFFFF, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_INIT_RADIUS, 20'd12800, 0, 0, 0, 0, 0);
      add_row(ROW_CSR, spvg_pkg::CSR_SPEED_X, 20'd72, 0, 0, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd1, 16'd256, 0, 0, 0);
      add_row(ROW_FRAME, spvg_pkg::CSR_START_X, 0, 16'd3, 16'd512, 0, 0, 0);

      foreach (stim_rows[k]) begin
         row = stim_rows[k];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_csr(row.index, row.wdata);
         end else begin
            send_frame(row.frame, row.scale, row);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         send_idle_pct = (ph / 2 == 0) ? 29 : (ph / 2 == 1) ? 58 : 0;
         recv_idle_pct = (ph / 2 == 0) ? 58 : (ph / 2 == 1) ? 29 : 0;
         random_config(ph == 1 || ph == 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               while (pending_vertices.size() != 0) @(posedge clock);
            end
            scale = ($urandom_range(9) < 7) ? 16'($urandom_range(200, 312)) : 16'($urandom);
            send_frame(16'($urandom), scale, plain);
         end
      end

      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- star_polygon_vertex_generator_unit.f -----
design/spvg_pkg.sv
design/spvg_mul.sv
design/spvg_div.sv
design/star_polygon_vertex_generator_unit.sv
verif/tb_top.sv
